@@ rtl/dmsc_pkg.sv @@
package dmsc_pkg;

	localparam int PIX_W      = 8;
	localparam int LW_W       = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int MIN_WIDTH  = 5;
	localparam int LINES      = 4;
	localparam int WIN_N      = 5;
	localparam int KSUM_W     = 15;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [KSUM_W-1:0] ksum_t;

	// lane k holds the sample of line k at one column, lane 0 the oldest line
	typedef pix_t [LINES-1:0] line_col_t;
	typedef pix_t [WIN_N-1:0] win_row_t;
	typedef win_row_t [WIN_N-1:0] win_t;

	typedef logic [2:0] rows_t;
	localparam rows_t ROWS_FULL = 3'd4;

	localparam ksum_t KSUM_PIX_MAX = 15'sd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH = 2'd0,
		REG_PHASE_X    = 2'd1,
		REG_PHASE_Y    = 2'd2
	} cfg_reg_t;

	// bayer phase of the centre, coded as {row parity, column parity}
	typedef enum logic [1:0] {
		PH_RED     = 2'b00,
		PH_GREEN_R = 2'b01,
		PH_GREEN_B = 2'b10,
		PH_BLUE    = 2'b11
	} phase_t;

	typedef struct packed {
		logic in_range;
		logic produce;
		logic row_end;
		logic xp;
		logic yp;
	} item_ctl_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
	} rgb_t;

	function automatic ksum_t ext_pix(pix_t p);
		return $signed({{(KSUM_W-PIX_W){1'b0}}, p});
	endfunction

	// sum in sixteenths down to 0..255
	function automatic pix_t to_u8(ksum_t s);
		ksum_t v;
		v = s >>> 4;
		if (s[KSUM_W-1] || (s == '0))
			return '0;
		else if (v > KSUM_PIX_MAX)
			return '1;
		else
			return v[PIX_W-1:0];
	endfunction

endpackage

@@ rtl/dmsc_if.sv @@
interface dmsc_pix_if;
	import dmsc_pkg::*;
	logic valid;
	logic ready;
	pix_t raw_pixel;
	logic frame_start;
	modport source(output valid, raw_pixel, frame_start, input ready);
	modport sink(input valid, raw_pixel, frame_start, output ready);
endinterface

interface dmsc_rgb_if;
	import dmsc_pkg::*;
	logic valid;
	logic ready;
	pix_t red;
	pix_t green;
	pix_t blue;
	logic row_end;
	modport source(output valid, red, green, blue, row_end, input ready);
	modport sink(input valid, red, green, blue, row_end, output ready);
endinterface

interface dmsc_cfg_if;
	import dmsc_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/bayer_rggb_hq_linear_demosaic.sv @@
// Streaming RGGB demosaic with the 5x5 high-quality linear kernels. Raw samples
// enter in raster order on raw, one per transfer, and one RGB pixel leaves on rgb
// for every centre at least two pixels inside each border; row_end marks the last
// pixel of each output row. The block takes one sample every cycle while rgb accepts
// its output, and holds raw off while rgb stalls the output; each sample passes
// the sample register (with the line store read), the 5x5 window and the output
// register. The four previous rows sit in one line store of MAX_WIDTH columns,
// four samples wide, read and written at most once per cycle, with no clearing pass
// after reset. Registers: 0 line width (clamped to 5..MAX_WIDTH), 1 column phase,
// 2 row phase; write them only while the block is idle.
module bayer_rggb_hq_linear_demosaic #(
	parameter int MAX_WIDTH = 2048
) (
	input logic        clk,
	input logic        arst_n,
	dmsc_pix_if.sink   raw,
	dmsc_rgb_if.source rgb,
	dmsc_cfg_if.sink   cfg
);
	import dmsc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [LW_W-1:0] lw_q;
	logic            phx_q;
	logic            phy_q;

	logic          in_xfer;
	logic [CW-1:0] col_cur;
	item_ctl_t     ctl_cur;

	logic          valid_s1;
	pix_t          px_s1;
	logic [CW-1:0] col_s1;
	item_ctl_t     ctl_s1;

	logic          valid_s2;
	item_ctl_t     ctl_s2;
	win_t          win_q;

	logic          out_valid_q;
	rgb_t          out_q;
	logic          out_end_q;

	line_col_t     rd_col;
	line_col_t     wr_col;
	rgb_t          kpix;

	logic          out_free;
	logic          s2_drain;
	logic          adv_s1;

	// config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q  <= LW_W'(640);
			phx_q <= 1'b0;
			phy_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LINE_WIDTH: lw_q  <= cfg.data[LW_W-1:0];
				REG_PHASE_X:    phx_q <= cfg.data[0];
				REG_PHASE_Y:    phy_q <= cfg.data[0];
				default:        ;
			endcase
		end
	end

	// flow control
	assign out_free  = !out_valid_q || rgb.ready;
	assign s2_drain  = valid_s2 && (!ctl_s2.produce || out_free);
	assign adv_s1    = valid_s1 && (!valid_s2 || s2_drain);
	assign raw.ready = !valid_s1 || adv_s1;
	assign in_xfer   = raw.valid && raw.ready;

	dmsc_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_xfer),
		.frame_start (raw.frame_start),
		.line_width  (lw_q),
		.phase_x     (phx_q),
		.phase_y     (phy_q),
		.col         (col_cur),
		.ctl         (ctl_cur)
	);

	// rotate the column: each line moves one older, the new sample becomes newest
	always_comb begin
		for (int k = 0; k < LINES - 1; k++)
			wr_col[k] = rd_col[k+1];
		wr_col[LINES-1] = px_s1;
	end

	dmsc_linemem #(
		.DEPTH(MAX_WIDTH)
	) u_linemem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (adv_s1 && ctl_s1.in_range),
		.wr_addr (col_s1),
		.wr_data (wr_col),
		.rd_en   (in_xfer),
		.rd_addr (col_cur),
		.rd_data (rd_col)
	);

	// sample stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_xfer)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_s1  <= raw.raw_pixel;
			col_s1 <= col_cur;
			ctl_s1 <= ctl_cur;
		end
	end

	// window stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s1)
			valid_s2 <= 1'b1;
		else if (s2_drain)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ctl_s2 <= ctl_s1;
			if (ctl_s1.in_range) begin
				for (int r = 0; r < WIN_N; r++)
					for (int k = 0; k < WIN_N - 1; k++)
						win_q[r][k] <= win_q[r][k+1];
				for (int r = 0; r < LINES; r++)
					win_q[r][WIN_N-1] <= rd_col[r];
				win_q[WIN_N-1][WIN_N-1] <= px_s1;
			end
		end
	end

	dmsc_kernel u_kernel (
		.win (win_q),
		.xp  (ctl_s2.xp),
		.yp  (ctl_s2.yp),
		.pix (kpix)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s2_drain && ctl_s2.produce)
			out_valid_q <= 1'b1;
		else if (rgb.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s2_drain && ctl_s2.produce) begin
			out_q     <= kpix;
			out_end_q <= ctl_s2.row_end;
		end
	end

	assign rgb.valid   = out_valid_q;
	assign rgb.red     = out_q.red;
	assign rgb.green   = out_q.green;
	assign rgb.blue    = out_q.blue;
	assign rgb.row_end = out_end_q;

`ifndef SYNTH
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> raw.ready)
		else $error("input stalled with empty sample stage");
`endif

endmodule

@@ rtl/dmsc_pos.sv @@
module dmsc_pos #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         frame_start,
	input  logic [dmsc_pkg::LW_W-1:0]    line_width,
	input  logic                         phase_x,
	input  logic                         phase_y,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output dmsc_pkg::item_ctl_t          ctl
);
	import dmsc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > LW_W) ? WW : LW_W;

	logic [CW-1:0] col_q;
	rows_t         rows_q;
	logic          par_q;

	logic [CW-1:0] col_cur;
	rows_t         rows_cur;
	logic          par_cur;
	logic [EW-1:0] lw_e;
	logic [EW-1:0] w_eff;
	logic [EW-1:0] col_e;
	logic          last;

	always_comb begin
		lw_e = EW'(line_width);
		if (lw_e < EW'(MIN_WIDTH))
			w_eff = EW'(MIN_WIDTH);
		else if (lw_e > EW'(MAX_WIDTH))
			w_eff = EW'(MAX_WIDTH);
		else
			w_eff = lw_e;
	end

	// frame start clears the position before the sample is placed
	assign col_cur  = frame_start ? '0 : col_q;
	assign rows_cur = frame_start ? '0 : rows_q;
	assign par_cur  = frame_start ? 1'b0 : par_q;
	assign col_e    = EW'(col_cur);
	assign last     = (col_e + EW'(1)) >= w_eff;

	assign col          = col_cur;
	assign ctl.in_range = col_e < w_eff;
	assign ctl.produce  = (col_e < w_eff) && (rows_cur == ROWS_FULL) && (col_cur >= CW'(4));
	assign ctl.row_end  = col_e == (w_eff - EW'(1));
	assign ctl.xp       = col_cur[0] ^ phase_x;
	assign ctl.yp       = par_cur ^ phase_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rows_q <= '0;
			par_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				col_q  <= '0;
				par_q  <= ~par_cur;
				rows_q <= (rows_cur == ROWS_FULL) ? ROWS_FULL : rows_cur + rows_t'(1);
			end else begin
				col_q  <= col_cur + CW'(1);
				par_q  <= par_cur;
				rows_q <= rows_cur;
			end
		end
	end

`ifndef SYNTH
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		EW'(col_q) < EW'(MAX_WIDTH))
		else $error("column count beyond line store");

	a_rows_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= ROWS_FULL)
		else $error("row count past saturation");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> (col_q == CW'(1)) && (rows_q == '0) && !par_q)
		else $error("frame start did not restart position");
`endif

endmodule

@@ rtl/dmsc_linemem.sv @@
module dmsc_linemem #(
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  dmsc_pkg::line_col_t      wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output dmsc_pkg::line_col_t      rd_data
);
	import dmsc_pkg::*;

	line_col_t mem [DEPTH];
	line_col_t rd_q;
	line_col_t byp_data_q;
	logic      byp_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// same column written in the read cycle: take the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byp_q <= 1'b0;
		else if (rd_en)
			byp_q <= wr_en && (wr_addr == rd_addr);
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

@@ rtl/dmsc_kernel.sv @@
module dmsc_kernel (
	input  dmsc_pkg::win_t win,
	input  logic           xp,
	input  logic           yp,
	output dmsc_pkg::rgb_t pix
);
	import dmsc_pkg::*;

	ksum_t s1, s2, s3, s4, s5, s6;
	ksum_t fa, fb, fc, fd;
	pix_t  ua, ub, uc, ud;
	pix_t  ctr;

	always_comb begin
		s1 = ext_pix(win[2][0]) + ext_pix(win[2][4]);
		s2 = ext_pix(win[0][2]) + ext_pix(win[4][2]);
		s3 = ext_pix(win[2][1]) + ext_pix(win[2][3]);
		s4 = ext_pix(win[1][2]) + ext_pix(win[3][2]);
		s5 = ext_pix(win[1][1]) + ext_pix(win[1][3]) + ext_pix(win[3][1]) + ext_pix(win[3][3]);
		s6 = ext_pix(win[2][2]);

		// weights in sixteenths
		fa = (s3 <<< 2) + (s4 <<< 2) + (s6 <<< 3) - (s1 <<< 1) - (s2 <<< 1);
		fb = s2 + (s3 <<< 3) + (s6 <<< 3) + (s6 <<< 1) - (s1 <<< 1) - (s5 <<< 1);
		fc = s1 + (s4 <<< 3) + (s6 <<< 3) + (s6 <<< 1) - (s2 <<< 1) - (s5 <<< 1);
		fd = (s5 <<< 2) + (s6 <<< 3) + (s6 <<< 2) - (s1 <<< 1) - s1 - (s2 <<< 1) - s2;

		ua  = to_u8(fa);
		ub  = to_u8(fb);
		uc  = to_u8(fc);
		ud  = to_u8(fd);
		ctr = win[2][2];

		case (phase_t'({yp, xp}))
			PH_RED: begin
				pix.red   = ctr;
				pix.green = ua;
				pix.blue  = ud;
			end
			PH_GREEN_R: begin
				pix.red   = ub;
				pix.green = ctr;
				pix.blue  = uc;
			end
			PH_GREEN_B: begin
				pix.red   = uc;
				pix.green = ctr;
				pix.blue  = ub;
			end
			PH_BLUE: begin
				pix.red   = ud;
				pix.green = ua;
				pix.blue  = ctr;
			end
			default: begin
				pix.red   = ctr;
				pix.green = ua;
				pix.blue  = ud;
			end
		endcase
	end

endmodule

@@ verif/testbench.sv @@
module testbench;
	import dmsc_pkg::*;

	localparam int MAX_W     = 2048;
	localparam int RUN_LIMIT = 8_000_000;
	localparam int TAIL      = 8;

	typedef struct {
		pix_t px;
		logic sof;
	} raw_item_t;

	typedef struct {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic row_end;
	} rgb_item_t;

	logic clk;
	logic arst_n;

	dmsc_pix_if raw_ch();
	dmsc_rgb_if rgb_ch();
	dmsc_cfg_if cfg_ch();

	bayer_rggb_hq_linear_demosaic #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw_ch),
		.rgb(rgb_ch),
		.cfg(cfg_ch)
	);

	raw_item_t pix_q[$];
	rgb_item_t rgb_exp_q[$];

	// shadow of the block state
	pix_t            line_mem[4][MAX_W];
	pix_t            win5[5][5];
	int              col_cnt;
	int              rows_cnt;
	logic            row_par;
	logic [LW_W-1:0] width_reg;
	logic            ph_x;
	logic            ph_y;

	int        fail_cnt;
	int        pushed_cnt;
	int        src_gap;
	int        snk_gap;
	int        src_calm;
	int        snk_calm;
	int        stall;
	raw_item_t launch;
	rgb_item_t made_rgb;
	rgb_item_t want_rgb;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic pix_t sixteenths_to_pix(input int s);
		int v;
		if (s <= 0)
			return '0;
		v = s >>> 4;
		if (v > 255)
			return 8'hff;
		return v[PIX_W-1:0];
	endfunction

	function automatic bit predict_rgb(input pix_t px, input logic sof, output rgb_item_t res);
		int w, c;
		int h_out, v_out, h_in, v_in, diag, ctr;
		int g_rb, rb_row, rb_col, rb_diag;
		logic xp, yp;
		bit made;
		made = 1'b0;
		res = '{default: '0};
		w = int'(width_reg);
		if (w < MIN_WIDTH)
			w = MIN_WIDTH;
		if (w > MAX_W)
			w = MAX_W;
		if (sof) begin
			col_cnt = 0;
			rows_cnt = 0;
			row_par = 1'b0;
		end
		c = col_cnt;
		if (c < w) begin
			for (int r = 0; r < 5; r++)
				for (int k = 0; k < 4; k++)
					win5[r][k] = win5[r][k+1];
			for (int k = 0; k < 4; k++)
				win5[k][4] = line_mem[k][c];
			win5[4][4] = px;
			for (int k = 0; k < 3; k++)
				line_mem[k][c] = line_mem[k+1][c];
			line_mem[3][c] = px;
			if (rows_cnt >= 4 && c >= 4) begin
				h_out = int'(win5[2][0]) + int'(win5[2][4]);
				v_out = int'(win5[0][2]) + int'(win5[4][2]);
				h_in = int'(win5[2][1]) + int'(win5[2][3]);
				v_in = int'(win5[1][2]) + int'(win5[3][2]);
				diag = int'(win5[1][1]) + int'(win5[1][3]) + int'(win5[3][1])
					+ int'(win5[3][3]);
				ctr = int'(win5[2][2]);
				g_rb = -2 * h_out - 2 * v_out + 4 * h_in + 4 * v_in + 8 * ctr;
				rb_row = -2 * h_out + v_out + 8 * h_in - 2 * diag + 10 * ctr;
				rb_col = h_out - 2 * v_out + 8 * v_in - 2 * diag + 10 * ctr;
				rb_diag = -3 * h_out - 3 * v_out + 4 * diag + 12 * ctr;
				xp = c[0] ^ ph_x;
				yp = row_par ^ ph_y;
				case (phase_t'({yp, xp}))
					PH_RED: begin
						res.red = win5[2][2];
						res.green = sixteenths_to_pix(g_rb);
						res.blue = sixteenths_to_pix(rb_diag);
					end
					PH_GREEN_R: begin
						res.green = win5[2][2];
						res.red = sixteenths_to_pix(rb_row);
						res.blue = sixteenths_to_pix(rb_col);
					end
					PH_GREEN_B: begin
						res.green = win5[2][2];
						res.red = sixteenths_to_pix(rb_col);
						res.blue = sixteenths_to_pix(rb_row);
					end
					PH_BLUE: begin
						res.blue = win5[2][2];
						res.red = sixteenths_to_pix(rb_diag);
						res.green = sixteenths_to_pix(g_rb);
					end
					default: ;
				endcase
				res.row_end = (c == w - 1);
				made = 1'b1;
			end
		end
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_par = ~row_par;
			if (rows_cnt < 4)
				rows_cnt++;
		end else begin
			col_cnt = c + 1;
		end
		return made;
	endfunction

	// mostly short gaps, a few long ones, now and then a calm stretch
	function automatic int draw_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(30, 150);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic pix_t draw_pixel(input int style);
		case (style)
			0: return PIX_W'($urandom_range(0, 255));
			1: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
			default: begin
				case ($urandom_range(0, 3))
					0: return 8'h00;
					1: return 8'hff;
					default: return PIX_W'($urandom_range(0, 255));
				endcase
			end
		endcase
	endfunction

	function automatic void push_pix(input pix_t p, input logic s);
		pix_q.push_back('{px: p, sof: s});
		pushed_cnt++;
	endfunction

	task automatic push_rows(input int rows, input int w, input int style, input logic sof);
		for (int i = 0; i < rows * w; i++)
			push_pix(draw_pixel(style), sof && (i == 0));
	endtask

	// everything sent and every pixel back, then let the pipeline settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pix_q.size() != 0 || rgb_exp_q.size() != 0 || raw_ch.valid);
		repeat (TAIL) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_LINE_WIDTH: width_reg = val;
			REG_PHASE_X:    ph_x = val[0];
			REG_PHASE_Y:    ph_y = val[0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	// raw sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			raw_ch.valid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (raw_ch.valid && raw_ch.ready) begin
				if (predict_rgb(raw_ch.raw_pixel, raw_ch.frame_start, made_rgb))
					rgb_exp_q.push_back(made_rgb);
			end
			if (!raw_ch.valid || raw_ch.ready) begin
				if (src_gap > 0) begin
					raw_ch.valid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (pix_q.size() != 0) begin
					launch = pix_q.pop_front();
					raw_ch.valid <= 1'b1;
					raw_ch.raw_pixel <= launch.px;
					raw_ch.frame_start <= launch.sof;
					src_gap <= draw_gap(src_calm);
				end else begin
					raw_ch.valid <= 1'b0;
				end
			end
		end
	end

	// rgb monitor and sink stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			rgb_ch.ready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (rgb_ch.valid && rgb_ch.ready) begin
				if (rgb_exp_q.size() == 0) begin
					$error("rgb transfer with nothing expected: %0d %0d %0d",
						rgb_ch.red, rgb_ch.green, rgb_ch.blue);
					fail_cnt++;
				end else begin
					want_rgb = rgb_exp_q.pop_front();
					if (rgb_ch.red !== want_rgb.red) begin
						$error("red: expected %0d, got %0d", want_rgb.red, rgb_ch.red);
						fail_cnt++;
					end
					if (rgb_ch.green !== want_rgb.green) begin
						$error("green: expected %0d, got %0d", want_rgb.green, rgb_ch.green);
						fail_cnt++;
					end
					if (rgb_ch.blue !== want_rgb.blue) begin
						$error("blue: expected %0d, got %0d", want_rgb.blue, rgb_ch.blue);
						fail_cnt++;
					end
					if (rgb_ch.row_end !== want_rgb.row_end) begin
						$error("row_end: expected %0b, got %0b", want_rgb.row_end,
							rgb_ch.row_end);
						fail_cnt++;
					end
				end
			end
			if (snk_gap > 0) begin
				rgb_ch.ready <= 1'b0;
				snk_gap <= snk_gap - 1;
			end else if ((rgb_ch.valid && rgb_ch.ready) || ($urandom_range(0, 7) == 0)) begin
				stall = draw_gap(snk_calm);
				rgb_ch.ready <= (stall == 0);
				snk_gap <= (stall > 0) ? stall - 1 : 0;
			end else begin
				rgb_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int w_sel, w_eff, rows, n_frames, kind, sty, n_junk;
		logic [CFG_DATA_W-1:0] w_val;

		arst_n = 1'b0;
		raw_ch.valid = 1'b0;
		raw_ch.raw_pixel = '0;
		raw_ch.frame_start = 1'b0;
		rgb_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_LINE_WIDTH;
		cfg_ch.data = '0;
		fail_cnt = 0;
		pushed_cnt = 0;
		src_calm = 0;
		snk_calm = 0;
		col_cnt = 0;
		rows_cnt = 0;
		row_par = 1'b0;
		width_reg = 12'd640;
		ph_x = 1'b0;
		ph_y = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// partial line at the power-up width: no row wraps, so no pixel comes back
		push_rows(1, 40, 0, 1'b1);
		wait_idle();

		// smallest frame: a single centre, top and bottom rows bright, inner rows checkered
		write_reg(REG_LINE_WIDTH, CFG_DATA_W'(5));
		write_reg(REG_PHASE_X, '0);
		write_reg(REG_PHASE_Y, '0);
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 5; c++)
				push_pix((r == 0 || r == 4 || ((r + c) % 2 == 1)) ? 8'hff : 8'h00,
					(r == 0) && (c == 0));
		wait_idle();

		// width below range saturates to the minimum
		write_reg(REG_LINE_WIDTH, '0);
		write_reg(REG_PHASE_X, CFG_DATA_W'(1));
		write_reg(REG_PHASE_Y, CFG_DATA_W'(1));
		push_rows(7, 5, 1, 1'b1);
		wait_idle();

		// narrow the line while the current row is past the new width
		write_reg(REG_LINE_WIDTH, CFG_DATA_W'(12));
		write_reg(REG_PHASE_X, '0);
		write_reg(REG_PHASE_Y, CFG_DATA_W'(1));
		push_rows(6, 12, 2, 1'b1);
		push_rows(1, 9, 2, 1'b0);
		wait_idle();
		write_reg(REG_LINE_WIDTH, CFG_DATA_W'(6));
		push_rows(4, 6, 2, 1'b0);
		wait_idle();

		// all-ones width saturates to the line store size; a short partial line
		write_reg(REG_LINE_WIDTH, 12'hfff);
		write_reg(REG_PHASE_X, CFG_DATA_W'(1));
		write_reg(REG_PHASE_Y, '0);
		push_rows(1, 20, 0, 1'b1);

		while (pushed_cnt < 330) begin
			wait_idle();
			w_sel = $urandom_range(0, 7);
			if (w_sel == 0) begin
				w_val = CFG_DATA_W'($urandom_range(13, 16));
				w_eff = int'(w_val);
			end else if (w_sel == 1) begin
				w_val = CFG_DATA_W'($urandom_range(0, 4));
				w_eff = MIN_WIDTH;
			end else begin
				w_val = CFG_DATA_W'($urandom_range(5, 12));
				w_eff = int'(w_val);
			end
			write_reg(REG_LINE_WIDTH, w_val);
			write_reg(REG_PHASE_X, CFG_DATA_W'($urandom_range(0, 1)));
			write_reg(REG_PHASE_Y, CFG_DATA_W'($urandom_range(0, 1)));
			n_frames = $urandom_range(1, 2);
			for (int f = 0; f < n_frames; f++) begin
				rows = $urandom_range(5, 6);
				sty = $urandom_range(0, 2);
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					// junk with stray frame starts, always opening a new frame
					n_junk = $urandom_range(5, 30);
					for (int i = 0; i < n_junk; i++)
						push_pix(draw_pixel(2), (i == 0) || ($urandom_range(0, 7) == 0));
				end else if (kind == 1) begin
					// frame cut off inside its last row
					push_rows(rows - 1, w_eff, sty, 1'b1);
					push_rows(1, $urandom_range(1, w_eff - 1), sty, 1'b0);
				end else begin
					push_rows(rows, w_eff, sty, 1'b1);
				end
				// sometimes hold the sender until the block has drained
				if (f == 0 && n_frames > 1 && $urandom_range(0, 3) == 0)
					wait_idle();
			end
		end

		wait_idle();
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
